// File: hdl/tss_pkg.sv
// Shared constants for the tridiagonal system solver.
// No dependencies; tss_if, the solver top level and the scoreboard refer to this package.
package tss_pkg;

   localparam int ROW_IDX_WIDTH = 6;

endpackage

// File: hdl/tss_if.sv
// Valid/ready channel interfaces for the row requests and the solution results.
// Depends on tss_pkg for the row index width.
interface tss_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sub_diag;
   logic signed [DATA_WIDTH-1:0] main_diag;
   logic signed [DATA_WIDTH-1:0] super_diag;
   logic signed [DATA_WIDTH-1:0] rhs_value;
   logic                         last_row;

   modport source (output valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                   input ready);
   modport sink (input valid, sub_diag, main_diag, super_diag, rhs_value, last_row,
                 output ready);
endinterface

interface tss_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                                 valid;
   logic                                 ready;
   logic signed [DATA_WIDTH-1:0]         solution;
   logic [tss_pkg::ROW_IDX_WIDTH-1:0]    row_index;
   logic                                 last_of_run;
   logic                                 singular;

   modport source (output valid, solution, row_index, last_of_run, singular, input ready);
   modport sink (input valid, solution, row_index, last_of_run, singular, output ready);
endinterface

// File: hdl/tss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/tss_div.sv
// Iterative restoring divider for signed fixed point: one quotient bit per cycle,
// saturating result. No dependencies.
module tss_div #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] numer,
   input  logic signed [DATA_WIDTH-1:0] denom,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] quotient
);

   localparam int W  = DATA_WIDTH;
   localparam int QW = DATA_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic [QW-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;
   logic [W:0]    rem_sh;
   logic [QW-1:0] limit;
   logic [W-1:0]  mag_n, mag_d, q_lo;

   always_comb begin
      mag_n  = numer[W-1] ? (~numer + W'(1)) : numer;
      mag_d  = denom[W-1] ? (~denom + W'(1)) : denom;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      res_in = res_ff;
      rem_sh = {rem_ff, dvd_ff[QW-1]};
      limit  = neg_ff ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      q_lo   = '0;
      if (start) begin
         dvd_in  = QW'(mag_n) << FRAC_BITS;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = mag_d;
         cnt_in  = CW'(QW);
         busy_in = 1'b1;
         neg_in  = numer[W-1] != denom[W-1];
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = W'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[W-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
         end else begin
            q_lo    = (quo_ff > limit) ? limit[W-1:0] : quo_ff[W-1:0];
            res_in  = neg_ff ? -q_lo : q_lo;
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

// File: hdl/tridiagonal_system_solver.sv
// Top level of the streaming tridiagonal solver (Thomas algorithm, signed fixed point).
// Depends on tss_pkg, tss_if, tss_ram and tss_div.
//
// Usage: one matrix row is sent per request on req_chan (sub-diagonal, diagonal,
// super-diagonal, right-hand side, last-row mark). Forward elimination runs as rows
// arrive and keeps the modified super-diagonal and right-hand side in two RAMs.
// After the last row (or the row that fills MAX_ROWS) the block back-substitutes and
// sends one result per row on rsp_chan in ascending row order.
// Each row waits on the bit-serial dividers. Back-substitution then reads, multiplies
// and subtracts for each row through the RAM read port and the multiplier, and each
// result is read from the RAM before it is loaded into the result register.
// Reset clears the row count and the singular flag; RAM contents need no clearing.
// When the receiver stalls, the result register holds and readout waits; the next
// system is accepted once the final result of a run sits in the result register.
module tridiagonal_system_solver #(
   parameter int MAX_ROWS   = 64,
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic     clock,
   input  logic     reset,
   tss_req_if.sink  req_chan,
   tss_rsp_if.source rsp_chan
);

   localparam int W  = DATA_WIDTH;
   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_ROWS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MULC, ST_MULD, ST_SUBD, ST_CHECK, ST_DIV, ST_WRITE,
      ST_BRD, ST_BMUL, ST_BSUB, ST_ORD, ST_OLD
   } state_type;

   state_type state_ff;
   logic [CW-1:0]       count_ff;
   logic                flag_ff, last_ff;
   logic [AW-1:0]       idx_ff, k_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff, d_ff, pivot_ff, num_ff, x_ff;
   logic [2*W-1:0]      prod_ff;
   logic                pneg_ff;
   logic                ov_ff;
   logic signed [W-1:0] sol_ff;
   logic [AW-1:0]       ridx_ff;
   logic                rlast_ff, rsing_ff;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [W-1:0]  wr_sup, wr_rhs, rd_sup, rd_rhs;
   logic          div_start, div_done_c, div_done_d;
   logic signed [W-1:0] cq, dq;
   logic [AW-1:0] cur_idx;
   logic          cur_last;
   logic signed [W-1:0] bsub_x;

   function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] v);
      mag_f = v[W-1] ? (~v + W'(1)) : v;
   endfunction

   function automatic logic signed [W-1:0] satmul_f(input logic [2*W-1:0] p,
                                                    input logic neg);
      logic [2*W-1:0] sh, lim;
      logic [W-1:0]   lo;
      sh  = p >> FRAC_BITS;
      lim = neg ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - (2*W)'(1));
      lo  = (sh > lim) ? lim[W-1:0] : sh[W-1:0];
      satmul_f = neg ? -lo : lo;
   endfunction

   function automatic logic signed [W-1:0] satsub_f(input logic signed [W-1:0] x,
                                                    input logic signed [W-1:0] y);
      logic signed [W:0] s;
      s = {x[W-1], x} - {y[W-1], y};
      if (s[W] != s[W-1]) begin
         satsub_f = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
         satsub_f = s[W-1:0];
      end
   endfunction

   assign cur_idx  = count_ff[AW-1:0];
   assign cur_last = req_chan.last_row || (cur_idx == AW'(MAX_ROWS - 1));
   assign bsub_x   = satsub_f(rd_rhs, satmul_f(prod_ff, pneg_ff));

   tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_super_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_sup),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_sup)
   );

   tss_ram #(.WIDTH(W), .DEPTH(MAX_ROWS)) u_rhs_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_rhs),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_rhs)
   );

   tss_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_super (
      .clock(clock), .reset(reset), .start(div_start), .numer(c_ff), .denom(pivot_ff),
      .done(div_done_c), .quotient(cq)
   );

   tss_div #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_rhs (
      .clock(clock), .reset(reset), .start(div_start), .numer(num_ff), .denom(pivot_ff),
      .done(div_done_d), .quotient(dq)
   );

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      div_start = 1'b0;
      rd_en   = 1'b0;
      rd_addr = k_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_sup  = '0;
      wr_rhs  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en   = req_chan.valid && (cur_idx != '0);
            rd_addr = cur_idx - AW'(1);
         end
         ST_CHECK: begin
            div_start = (pivot_ff != '0);
         end
         ST_WRITE: begin
            wr_en  = 1'b1;
            wr_sup = (last_ff || ov_ff) ? '0 : cq;
            wr_rhs = ov_ff ? '0 : dq;
         end
         ST_BRD: begin
            rd_en = 1'b1;
         end
         ST_BSUB: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            wr_sup  = rd_sup;
            wr_rhs  = bsub_x;
         end
         ST_ORD: begin
            rd_en = !rsp_chan.valid || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         flag_ff  <= 1'b0;
         rsp_chan.valid <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_chan.valid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  a_ff    <= req_chan.sub_diag;
                  b_ff    <= req_chan.main_diag;
                  c_ff    <= req_chan.super_diag;
                  d_ff    <= req_chan.rhs_value;
                  last_ff <= cur_last;
                  idx_ff  <= cur_idx;
                  pivot_ff <= req_chan.main_diag;
                  num_ff  <= req_chan.rhs_value;
                  state_ff <= (cur_idx == '0) ? ST_CHECK : ST_MULC;
               end
            end
            ST_MULC: begin
               prod_ff  <= (2*W)'(mag_f(a_ff)) * (2*W)'(mag_f(rd_sup));
               pneg_ff  <= a_ff[W-1] != rd_sup[W-1];
               state_ff <= ST_MULD;
            end
            ST_MULD: begin
               pivot_ff <= satsub_f(b_ff, satmul_f(prod_ff, pneg_ff));
               prod_ff  <= (2*W)'(mag_f(a_ff)) * (2*W)'(mag_f(rd_rhs));
               pneg_ff  <= a_ff[W-1] != rd_rhs[W-1];
               state_ff <= ST_SUBD;
            end
            ST_SUBD: begin
               num_ff   <= satsub_f(d_ff, satmul_f(prod_ff, pneg_ff));
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               ov_ff <= (pivot_ff == '0);
               if (pivot_ff == '0) begin
                  flag_ff  <= 1'b1;
                  state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done_c && div_done_d) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               count_ff <= CW'(idx_ff) + CW'(1);
               x_ff     <= ov_ff ? '0 : dq;
               if (!last_ff) begin
                  state_ff <= ST_IDLE;
               end else if (idx_ff == '0) begin
                  k_ff     <= '0;
                  state_ff <= ST_ORD;
               end else begin
                  k_ff     <= idx_ff - AW'(1);
                  state_ff <= ST_BRD;
               end
            end
            ST_BRD: begin
               state_ff <= ST_BMUL;
            end
            ST_BMUL: begin
               prod_ff  <= (2*W)'(mag_f(rd_sup)) * (2*W)'(mag_f(x_ff));
               pneg_ff  <= rd_sup[W-1] != x_ff[W-1];
               state_ff <= ST_BSUB;
            end
            ST_BSUB: begin
               x_ff <= bsub_x;
               if (k_ff == '0) begin
                  state_ff <= ST_ORD;
               end else begin
                  k_ff     <= k_ff - AW'(1);
                  state_ff <= ST_BRD;
               end
            end
            ST_ORD: begin
               if (!rsp_chan.valid || rsp_chan.ready) begin
                  state_ff <= ST_OLD;
               end
            end
            ST_OLD: begin
               rsp_chan.valid <= 1'b1;
               sol_ff   <= rd_rhs;
               ridx_ff  <= k_ff;
               rlast_ff <= (k_ff == idx_ff);
               rsing_ff <= flag_ff;
               if (k_ff == idx_ff) begin
                  count_ff <= '0;
                  flag_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff     <= k_ff + AW'(1);
                  state_ff <= ST_ORD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.solution    = sol_ff;
   assign rsp_chan.row_index   = tss_pkg::ROW_IDX_WIDTH'(ridx_ff);
   assign rsp_chan.last_of_run = rlast_ff;
   assign rsp_chan.singular    = rsing_ff;

endmodule

// File: dv/tss_scoreboard.sv
// Scoreboard class for the tridiagonal solver testbench: fixed-point Thomas predictor
// and an ordered store of expected solutions. Depends on tss_pkg.
package tss_scoreboard_pkg;

   typedef struct packed {
      logic signed [31:0]              solution;
      logic [tss_pkg::ROW_IDX_WIDTH-1:0] row_index;
      logic                            last_of_run;
      logic                            singular;
   } solution_type;

   class tss_scoreboard_type;
      localparam longint MAXPOS = 64'sh7FFF_FFFF;
      localparam longint MAXNEG = -64'sh8000_0000;
      longint   cprime[64];
      longint   dprime[64];
      int       rows_seen;
      bit       zero_pivot;
      solution_type pending_solutions[$];
      int       mismatch_count;

      function new();
         rows_seen = 0;
         zero_pivot = 0;
         mismatch_count = 0;
      endfunction

      function longint clamp(logic signed [127:0] v);
         if (v > MAXPOS) return MAXPOS;
         if (v < MAXNEG) return MAXNEG;
         return longint'(v);
      endfunction

      function longint fx_sub(longint a, longint b);
         logic signed [127:0] r;
         r = 128'(a) - 128'(b);
         return clamp(r);
      endfunction

      // Products and quotients truncate toward zero on the magnitude.
      function longint fx_mul(longint a, longint b);
         logic [127:0] m;
         logic signed [127:0] r;
         m = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b)) >> 16;
         r = ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
         return clamp(r);
      endfunction

      function longint fx_div(longint n, longint d);
         logic [127:0] m;
         logic signed [127:0] r;
         m = (128'(n < 0 ? -n : n) << 16) / 128'(d < 0 ? -d : d);
         r = ((n < 0) != (d < 0)) ? -$signed(m) : $signed(m);
         return clamp(r);
      endfunction

      function void note_row(logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c, logic signed [31:0] d, logic last);
         longint pivot, num, cq, dq;
         int idx, k;
         solution_type s;
         idx = rows_seen;
         cq = 0;
         dq = 0;
         if (idx == 0) begin
            pivot = b;
            num = d;
         end else begin
            pivot = fx_sub(b, fx_mul(a, cprime[idx-1]));
            num = fx_sub(d, fx_mul(a, dprime[idx-1]));
         end
         if (idx + 1 >= 64) last = 1;
         if (pivot == 0) begin
            zero_pivot = 1;
         end else begin
            if (!last) cq = fx_div(c, pivot);
            dq = fx_div(num, pivot);
         end
         cprime[idx] = cq;
         dprime[idx] = dq;
         rows_seen = idx + 1;
         if (!last) return;
         for (k = idx - 1; k >= 0; k--)
            dprime[k] = fx_sub(dprime[k], fx_mul(cprime[k], dprime[k+1]));
         for (k = 0; k <= idx; k++) begin
            s.solution = dprime[k][31:0];
            s.row_index = k[5:0];
            s.last_of_run = (k == idx);
            s.singular = zero_pivot;
            pending_solutions.push_back(s);
         end
         rows_seen = 0;
         zero_pivot = 0;
      endfunction

      function void check_solution(solution_type got);
         solution_type want;
         if (pending_solutions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %p", got);
            return;
         end
         want = pending_solutions.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Expected %p, got %p", want, got);
         end
      endfunction
   endclass

endpackage

// File: dv/tridiagonal_system_solver_tb.sv
// Testbench top for the tridiagonal solver: random and directed row streams with
// random idling on both channels. Depends on tss_pkg, tss_if and tss_scoreboard_pkg.
module tridiagonal_system_solver_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off = 0;
   bit   driving_done = 0;
   tss_scoreboard_pkg::tss_scoreboard_type board = new();

   tss_req_if req_chan ();
   tss_rsp_if rsp_chan ();

   tridiagonal_system_solver i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always #10 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      req_chan.sub_diag = 0;
      req_chan.main_diag = 0;
      req_chan.super_diag = 0;
      req_chan.rhs_value = 0;
      req_chan.last_row = 0;
      rsp_chan.ready = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_row(req_chan.sub_diag, req_chan.main_diag, req_chan.super_diag,
                        req_chan.rhs_value, req_chan.last_row);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_solution({rsp_chan.solution, rsp_chan.row_index,
                               rsp_chan.last_of_run, rsp_chan.singular});
   end

   always @(negedge clock)
      rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 0;
         default: return $signed($urandom_range(8 << 16)) - (4 << 16);
      endcase
   endfunction

   // The block drops ready right after it takes a request, so valid may stay high
   // until the next request or the next idle cycle.
   task automatic send_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.sub_diag <= a;
      req_chan.main_diag <= b;
      req_chan.super_diag <= c;
      req_chan.rhs_value <= d;
      req_chan.last_row <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Main diagonal mostly between 3.0 and 9.0, with arbitrary coefficients mixed in.
   task automatic send_system(int n);
      logic [31:0] b;
      for (int r = 0; r < n; r++) begin
         if ($urandom_range(3) == 0) b = rand_coef();
         else b = $signed($urandom_range(6 << 16)) + (3 << 16);
         send_row(rand_coef(), b, rand_coef(), rand_coef(), r == n - 1);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 0;
      while (board.pending_solutions.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   initial begin
      int sent;
      repeat (5) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_row(0, 2 << 16, 0, 6 << 16, 1);
      send_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1);
      send_row(32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_row(5, 0, 7, 9 << 16, 1);
      send_row(32'hFFFF_FFFF, 1 << 16, 1 << 16, 1 << 16, 0);
      send_row(1 << 16, 1 << 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_row(1 << 16, 0, 1 << 16, 2 << 16, 0);
      send_row(1 << 16, 3 << 16, 1 << 16, 32'h8000_0000, 0);
      send_row(32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
      for (int r = 0; r < 64; r++)
         send_row(1 << 16, 4 << 16, 1 << 16, r << 16, 0);
      drain();
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? 63 : 0;
         recv_stall_pct = phase == 2 ? 63 : (phase == 3 ? 14 : 0);
         if (phase == 3) send_idle_pct = 14;
         if (phase == 0) begin
            fork
               begin
                  hold_off = 1;
                  repeat (3000) @(negedge clock);
                  hold_off = 0;
               end
               repeat (3) send_system(6);
            join
            sent += 18;
         end
         while (sent < 85 * (phase + 1)) begin
            int n;
            n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(1, 8);
            if (n == 0) n = 1;
            send_system(n);
            sent += n;
         end
         drain();
      end
      driving_done = 1;
   end

   initial begin
      wait (driving_done);
      if (board.mismatch_count == 0 && board.pending_solutions.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

// File: filelist.f
hdl/tss_pkg.sv
hdl/tss_if.sv
hdl/tss_ram.sv
hdl/tss_div.sv
hdl/tridiagonal_system_solver.sv
dv/tss_scoreboard.sv
dv/tridiagonal_system_solver_tb.sv
